/* design/ezq_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ezq_pkg
// Shared widths, polynomial coefficients and stage types of the Z-Y-Z Euler
// angle to quaternion converter.
// ---------------------------------------------------------------------------
package ezq_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int COMP_BITS  = 16;

   // half-angle magnitude and its square, Q30
   localparam int X_W    = 31;
   // Horner accumulator, signed Q30
   localparam int P_W    = 33;
   localparam int FRAC   = 30;
   // half-angle trig values, signed Q1.15
   localparam int TRIG_W = 17;
   // first Hamilton product, scale 2^30
   localparam int AB_W   = 32;
   // second Hamilton product, scale 2^45
   localparam int Q_W    = 48;
   localparam int OUT_SHIFT = 45 - (COMP_BITS - 2);
   localparam int N_CELLS   = 5;
   localparam int N_LANES   = 3;
   localparam int STEP_W    = 3;

   typedef struct packed {
      logic [X_W-1:0]        x;
      logic [X_W-1:0]        x2;
      logic signed [P_W-1:0] ps;
      logic signed [P_W-1:0] pc;
      logic                  neg;
   } lane_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] c;
      logic signed [TRIG_W-1:0] s;
   } trig_type;

   typedef struct packed {
      logic signed [Q_W-1:0] w;
      logic signed [Q_W-1:0] x;
      logic signed [Q_W-1:0] y;
      logic signed [Q_W-1:0] z;
   } quat_type;

   // sin(pi/2 x) odd coefficients, degree 11 down to 1
   function automatic logic signed [P_W-1:0] sin_coef(input logic [STEP_W-1:0] idx);
      logic signed [P_W-1:0] r;
      unique case (idx)
         3'd0:    r = P_W'(3864);
         3'd1:    r = P_W'(172272);
         3'd2:    r = P_W'(5026995);
         3'd3:    r = P_W'(85569306);
         3'd4:    r = P_W'(693598668);
         3'd5:    r = P_W'(1686629713);
         default: r = '0;
      endcase
      return r;
   endfunction

   // cos(pi/2 x) even coefficients, degree 12 down to 2
   function automatic logic signed [P_W-1:0] cos_coef(input logic [STEP_W-1:0] idx);
      logic signed [P_W-1:0] r;
      unique case (idx)
         3'd0:    r = P_W'(506);
         3'd1:    r = P_W'(27060);
         3'd2:    r = P_W'(987048);
         3'd3:    r = P_W'(22401992);
         3'd4:    r = P_W'(272375560);
         3'd5:    r = P_W'(1324675879);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* design/ezq_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ezq_req_if / ezq_rsp_if
// Valid/ready channels carrying the Euler angles and the quaternion result.
// ---------------------------------------------------------------------------
interface ezq_req_if;
   import ezq_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] alpha_angle;
   logic signed [ANGLE_BITS-1:0] beta_angle;
   logic signed [ANGLE_BITS-1:0] gamma_angle;

   modport source (output valid, alpha_angle, beta_angle, gamma_angle, input ready);
   modport sink   (input valid, alpha_angle, beta_angle, gamma_angle, output ready);
endinterface

interface ezq_rsp_if;
   import ezq_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [COMP_BITS-1:0] quat_w;
   logic signed [COMP_BITS-1:0] quat_x;
   logic signed [COMP_BITS-1:0] quat_y;
   logic signed [COMP_BITS-1:0] quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

/* design/ezq_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ezq_cell
// One Horner step of the half-angle sine and cosine polynomials.
// ---------------------------------------------------------------------------
module ezq_cell
   import ezq_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [STEP_W-1:0] step,
   input  lane_type          lane_i,
   output lane_type          lane_ff
);

   logic signed [2*P_W-1:0] prod_s;
   logic signed [2*P_W-1:0] prod_c;
   lane_type                lane_in;

   always_comb begin
      prod_s = $signed({1'b0, lane_i.x2}) * lane_i.ps;
      prod_c = $signed({1'b0, lane_i.x2}) * lane_i.pc;
      lane_in    = lane_i;
      lane_in.ps = sin_coef(step) - P_W'(prod_s >>> FRAC);
      lane_in.pc = cos_coef(step) - P_W'(prod_c >>> FRAC);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
      end
   end

endmodule

/* design/ezq_quat.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ezq_quat
// Two registered Hamilton products (qa*qb)*qg specialised to Z-Y-Z axes.
// ---------------------------------------------------------------------------
module ezq_quat
   import ezq_pkg::*;
(
   input  logic     clock,
   input  logic     en_ab,
   input  logic     en_q,
   input  trig_type ta,
   input  trig_type tb,
   input  trig_type tg,
   output quat_type q_ff
);

   logic signed [AB_W-1:0]   abw_ff, abx_ff, aby_ff, abz_ff;
   logic signed [AB_W-1:0]   abw_in, abx_in, aby_in, abz_in;
   logic signed [TRIG_W-1:0] cg_ff, sg_ff;
   quat_type                 q_in;

   always_comb begin
      abw_in = AB_W'(ta.c * tb.c);
      abx_in = AB_W'(-(tb.s * ta.s));
      aby_in = AB_W'(ta.c * tb.s);
      abz_in = AB_W'(tb.c * ta.s);
   end

   always_comb begin
      q_in.w = Q_W'(abw_ff * cg_ff - abz_ff * sg_ff);
      q_in.x = Q_W'(abx_ff * cg_ff + aby_ff * sg_ff);
      q_in.y = Q_W'(aby_ff * cg_ff - abx_ff * sg_ff);
      q_in.z = Q_W'(abw_ff * sg_ff + abz_ff * cg_ff);
   end

   always_ff @(posedge clock) begin
      if (en_ab) begin
         abw_ff <= abw_in;
         abx_ff <= abx_in;
         aby_ff <= aby_in;
         abz_ff <= abz_in;
         cg_ff  <= tg.c;
         sg_ff  <= tg.s;
      end
      if (en_q) begin
         q_ff <= q_in;
      end
   end

endmodule

/* design/euler_zyz_to_quaternion.sv */
`timescale 1ns / 1ps
// Throughput: one request per cycle while the output is not stalled; the stage
// chain is eleven registers deep, each stage advancing whenever it is empty or
// the one after it moves.
// Reset clears every stage valid bit and the output valid; payload is not reset.
// ---------------------------------------------------------------------------
// euler_zyz_to_quaternion
// Z-Y-Z Euler binary angles to a rounded, saturated Q2.14 quaternion.
// ---------------------------------------------------------------------------
module euler_zyz_to_quaternion
   import ezq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ezq_req_if.sink   req_chan,
   ezq_rsp_if.source rsp_chan
);

   localparam int N_STG  = 11;
   localparam int S_CELL = 2;
   localparam int S_TRIG = S_CELL + N_CELLS;

   logic [N_STG-1:0] vld_ff;
   logic [N_STG-1:0] en;

   lane_type lane0_ff [N_LANES];
   lane_type lane1_ff [N_LANES];
   lane_type chain    [N_LANES][N_CELLS+1];
   trig_type trig_ff  [N_LANES];
   quat_type q_ff;

   logic signed [COMP_BITS-1:0] w_ff, x_ff, y_ff, z_ff;

   // stage enables: advance when empty or when the next stage advances
   always_comb begin
      en[N_STG-1] = !vld_ff[N_STG-1] || rsp_chan.ready;
      for (int k = N_STG - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_chan.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < N_STG; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   for (genvar l = 0; l < N_LANES; l++) begin : g_lane
      logic signed [ANGLE_BITS-1:0] ang;
      logic [ANGLE_BITS:0]          mag;
      lane_type                     l0_in, l1_in;
      logic [2*X_W-1:0]             sq;
      logic signed [2*P_W-1:0]      ps_prod, pc_prod;
      logic signed [P_W:0]          sv, cv;
      logic [X_W-1:0]               sv_c, cv_c;
      logic [TRIG_W-1:0]            s_mag, c_mag;
      trig_type                     t_in;

      always_comb begin
         unique case (l)
            0:       ang = req_chan.alpha_angle;
            1:       ang = req_chan.beta_angle;
            default: ang = req_chan.gamma_angle;
         endcase
         mag = ang[ANGLE_BITS-1] ? (ANGLE_BITS+1)'(-ang) : (ANGLE_BITS+1)'(ang);
         l0_in     = '0;
         l0_in.neg = ang[ANGLE_BITS-1];
         l0_in.x   = X_W'({mag, {(X_W-ANGLE_BITS){1'b0}}});
      end

      always_comb begin
         sq       = lane0_ff[l].x * lane0_ff[l].x;
         l1_in    = lane0_ff[l];
         l1_in.x2 = X_W'(sq >> FRAC);
         l1_in.ps = sin_coef(STEP_W'(0));
         l1_in.pc = cos_coef(STEP_W'(0));
      end

      always_ff @(posedge clock) begin
         if (en[0]) begin
            lane0_ff[l] <= l0_in;
         end
         if (en[1]) begin
            lane1_ff[l] <= l1_in;
         end
      end

      assign chain[l][0] = lane1_ff[l];

      for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
         ezq_cell u_cell (
            .clock   (clock),
            .en      (en[S_CELL+c]),
            .step    (STEP_W'(c + 1)),
            .lane_i  (chain[l][c]),
            .lane_ff (chain[l][c+1])
         );
      end

      // final multiply, clamp to [0, 1] and round to Q1.15
      always_comb begin
         ps_prod = $signed({1'b0, chain[l][N_CELLS].x})  * chain[l][N_CELLS].ps;
         pc_prod = $signed({1'b0, chain[l][N_CELLS].x2}) * chain[l][N_CELLS].pc;
         sv = (P_W+1)'(ps_prod >>> FRAC);
         cv = (P_W+1)'(1 << FRAC) - (P_W+1)'(pc_prod >>> FRAC);
         if (sv < 0) begin
            sv_c = '0;
         end else if (sv > (P_W+1)'(1 << FRAC)) begin
            sv_c = X_W'(1 << FRAC);
         end else begin
            sv_c = X_W'(sv);
         end
         if (cv < 0) begin
            cv_c = '0;
         end else if (cv > (P_W+1)'(1 << FRAC)) begin
            cv_c = X_W'(1 << FRAC);
         end else begin
            cv_c = X_W'(cv);
         end
         s_mag = TRIG_W'((sv_c + X_W'(1 << 14)) >> 15);
         c_mag = TRIG_W'((cv_c + X_W'(1 << 14)) >> 15);
         t_in.c = $signed(c_mag);
         t_in.s = chain[l][N_CELLS].neg ? -$signed(s_mag) : $signed(s_mag);
      end

      always_ff @(posedge clock) begin
         if (en[S_TRIG]) begin
            trig_ff[l] <= t_in;
         end
      end
   end

   ezq_quat u_quat (
      .clock (clock),
      .en_ab (en[S_TRIG+1]),
      .en_q  (en[S_TRIG+2]),
      .ta    (trig_ff[0]),
      .tb    (trig_ff[1]),
      .tg    (trig_ff[2]),
      .q_ff  (q_ff)
   );

   // round half up, then saturate to the output range
   function automatic logic signed [COMP_BITS-1:0] to_out(input logic signed [Q_W-1:0] v);
      logic signed [Q_W:0] r;
      logic signed [Q_W:0] hi;
      logic signed [Q_W:0] lo;
      hi = (Q_W+1)'((1 << (COMP_BITS - 1)) - 1);
      lo = -hi - (Q_W+1)'(1);
      r  = ((Q_W+1)'(v) + (Q_W+1)'(64'sd1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
      if (r > hi) begin
         r = hi;
      end else if (r < lo) begin
         r = lo;
      end
      return COMP_BITS'(r);
   endfunction

   always_ff @(posedge clock) begin
      if (en[N_STG-1]) begin
         w_ff <= to_out(q_ff.w);
         x_ff <= to_out(q_ff.x);
         y_ff <= to_out(q_ff.y);
         z_ff <= to_out(q_ff.z);
      end
   end

   assign rsp_chan.valid  = vld_ff[N_STG-1];
   assign rsp_chan.quat_w = w_ff;
   assign rsp_chan.quat_x = x_ff;
   assign rsp_chan.quat_y = y_ff;
   assign rsp_chan.quat_z = z_ff;

endmodule

/* design/ezq_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ezq_checker
// Port-level checks of the converter handshake and stall behaviour.
// ---------------------------------------------------------------------------
module ezq_checker
   import ezq_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [COMP_BITS-1:0] rsp_w,
   input logic signed [COMP_BITS-1:0] rsp_x,
   input logic signed [COMP_BITS-1:0] rsp_y,
   input logic signed [COMP_BITS-1:0] rsp_z
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_w) && $stable(rsp_x)
                                  && $stable(rsp_y) && $stable(rsp_z))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused without output back-pressure");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not cleared by reset");

endmodule

bind euler_zyz_to_quaternion ezq_checker u_ezq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_w     (rsp_chan.quat_w),
   .rsp_x     (rsp_chan.quat_x),
   .rsp_y     (rsp_chan.quat_y),
   .rsp_z     (rsp_chan.quat_z)
);

/* tb/tb_euler_zyz_to_quaternion.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_euler_zyz_to_quaternion
// Drives Z-Y-Z binary angle requests through the converter with random
// idling on both channels, predicts each quaternion in integer arithmetic
// and compares every result in order, component by component.
// ---------------------------------------------------------------------------
module tb_euler_zyz_to_quaternion;
   import ezq_pkg::*;

   typedef struct packed {
      logic signed [COMP_BITS-1:0] w;
      logic signed [COMP_BITS-1:0] x;
      logic signed [COMP_BITS-1:0] y;
      logic signed [COMP_BITS-1:0] z;
   } comp_set_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;

   ezq_req_if req_chan ();
   ezq_rsp_if rsp_chan ();

   euler_zyz_to_quaternion u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   comp_set_type quat_queue[$];
   int           mismatch_count = 0;
   int           idle_cycles    = 0;
   bit           send_gaps      = 1'b1;
   bit           sink_gaps      = 1'b1;
   bit           hold_off       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // half-angle cosine and sine, Q1.15
   function automatic void half_angle_trig(logic [ANGLE_BITS-1:0] raw,
                                           output longint c15, output longint s15);
      longint sin_k[6];
      longint cos_k[6];
      longint a, u, x, x2, p, cv, sv;
      bit     neg;
      sin_k = '{3864, 172272, 5026995, 85569306, 693598668, 1686629713};
      cos_k = '{506, 27060, 987048, 22401992, 272375560, 1324675879};
      a   = longint'($signed(raw));
      neg = a < 0;
      u   = a * (64'sd1 <<< (32 - ANGLE_BITS));
      if (neg) u = -u;
      x  = u >>> 1;
      x2 = floor_shift(x * x, 30);
      p = sin_k[0];
      for (int i = 1; i < 6; i++) p = sin_k[i] - floor_shift(x2 * p, 30);
      sv = floor_shift(x * p, 30);
      p = cos_k[0];
      for (int i = 1; i < 6; i++) p = cos_k[i] - floor_shift(x2 * p, 30);
      cv = (64'sd1 <<< 30) - floor_shift(x2 * p, 30);
      if (sv < 0) sv = 0;
      if (sv > (64'sd1 <<< 30)) sv = 64'sd1 <<< 30;
      if (cv < 0) cv = 0;
      if (cv > (64'sd1 <<< 30)) cv = 64'sd1 <<< 30;
      c15 = (cv + (64'sd1 <<< 14)) >>> 15;
      sv  = (sv + (64'sd1 <<< 14)) >>> 15;
      s15 = neg ? -sv : sv;
   endfunction

   function automatic logic signed [COMP_BITS-1:0] round_sat(longint v);
      longint hi, lo, r;
      hi = (64'sd1 <<< (COMP_BITS - 1)) - 1;
      lo = -hi - 1;
      r  = floor_shift(v + (64'sd1 <<< (OUT_SHIFT - 1)), OUT_SHIFT);
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r[COMP_BITS-1:0];
   endfunction

   function automatic comp_set_type predict_quat(logic [ANGLE_BITS-1:0] al,
                                                 logic [ANGLE_BITS-1:0] be,
                                                 logic [ANGLE_BITS-1:0] ga);
      longint ca, sa, cb, sb, cg, sg;
      longint abw, abx, aby, abz;
      comp_set_type q;
      half_angle_trig(al, ca, sa);
      half_angle_trig(be, cb, sb);
      half_angle_trig(ga, cg, sg);
      // qa = (ca,0,0,sa), qb = (cb,0,sb,0), qg = (cg,0,0,sg)
      abw = ca * cb;
      abx = -(sb * sa);
      aby = ca * sb;
      abz = cb * sa;
      q.w = round_sat(abw * cg - abz * sg);
      q.x = round_sat(abx * cg + aby * sg);
      q.y = round_sat(aby * cg - abx * sg);
      q.z = round_sat(abw * sg + cg * abz);
      return q;
   endfunction

   task automatic send_angles(logic [ANGLE_BITS-1:0] al, logic [ANGLE_BITS-1:0] be,
                              logic [ANGLE_BITS-1:0] ga);
      if (send_gaps && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.alpha_angle <= al;
      req_chan.beta_angle  <= be;
      req_chan.gamma_angle <= ga;
      quat_queue.push_back(predict_quat(al, be, ga));
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic drop_valid();
      req_chan.valid <= 1'b0;
   endtask

   function automatic logic [ANGLE_BITS-1:0] rand_angle();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'(16'h4000 + $urandom_range(0, 4) - 2);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [ANGLE_BITS-1:0] edges[8];
      edges = '{16'h0000, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h4000,
                16'hc000, 16'h8001};
      for (int i = 0; i < 8; i++) send_angles(edges[i], edges[(i+3)%8], edges[(i+5)%8]);
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'h7fff, 16'h7fff, 16'h7fff);
      send_angles(16'h0000, 16'h0000, 16'h0000);
      send_angles(16'haaaa, 16'h5555, 16'haaaa);
      send_angles(16'h5555, 16'haaaa, 16'h5555);
      send_angles(16'h2000, 16'h2000, 16'h2000);
   endtask

   task automatic test_random(int n);
      for (int i = 0; i < n; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
   endtask

   // hold the result side while requests keep coming, so the pipe fills
   task automatic test_backpressure();
      hold_off = 1'b1;
      send_gaps = 1'b0;
      fork
         begin
            repeat (60) @(posedge clock);
            hold_off = 1'b0;
         end
         test_random(40);
      join
      send_gaps = 1'b1;
   endtask

   task automatic test_streaming();
      send_gaps = 1'b0;
      sink_gaps = 1'b0;
      test_random(250);
   endtask

   task automatic check_result();
      comp_set_type exp_q, got_q;
      if (rsp_chan.valid && rsp_chan.ready) begin
         got_q = '{rsp_chan.quat_w, rsp_chan.quat_x, rsp_chan.quat_y, rsp_chan.quat_z};
         if (quat_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", got_q);
         end else begin
            exp_q = quat_queue.pop_front();
            if (got_q !== exp_q) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p got %p", exp_q, got_q);
            end
         end
      end
   endtask

   // result side: random stalls, compare against the oldest prediction
   initial begin
      rsp_chan.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         check_result();
         if (hold_off) rsp_chan.ready <= 1'b0;
         else if (sink_gaps && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) begin
               @(posedge clock);
               check_result();
            end
            rsp_chan.ready <= 1'b1;
         end else rsp_chan.ready <= 1'b1;
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int guard;
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.alpha_angle <= '0;
      req_chan.beta_angle  <= '0;
      req_chan.gamma_angle <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(700);
      test_backpressure();
      test_random(300);
      test_streaming();
      drop_valid();
      guard = 0;
      while (quat_queue.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && quat_queue.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
